// ===== design/mau_pkg.sv =====
// shared types and constants of the modular arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
package mau_pkg;

    localparam int RESIDUE_WIDTH = 31;
    localparam int MAX_K         = 64;
    localparam int WIDE_W        = 64;
    localparam int EXP_W         = 63;
    localparam int OP_W          = 4;
    localparam int MUL_CNT_W     = $clog2(RESIDUE_WIDTH + 1);
    localparam int RED_CNT_W     = $clog2(WIDE_W + 1);
    localparam int KCNT_W        = $clog2(MAX_K + 1);

    typedef logic [RESIDUE_WIDTH-1:0] t_residue;
    typedef logic [RESIDUE_WIDTH:0]   t_residue_x;
    typedef logic [WIDE_W-1:0]        t_wide;
    typedef logic [EXP_W-1:0]         t_exp;
    typedef logic [KCNT_W-1:0]        t_kcnt;
    typedef logic [OP_W-1:0]          t_op;

    localparam t_residue MOD_RESET = t_residue'(1000000007);

    localparam t_op OP_ADD    = 4'd0;
    localparam t_op OP_SUB    = 4'd1;
    localparam t_op OP_MUL    = 4'd2;
    localparam t_op OP_DIV    = 4'd3;
    localparam t_op OP_NEG    = 4'd4;
    localparam t_op OP_POW    = 4'd5;
    localparam t_op OP_INV    = 4'd6;
    localparam t_op OP_REDUCE = 4'd7;
    localparam t_op OP_BINOM  = 4'd8;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_ser_stat;

endpackage
`default_nettype wire

// ===== design/mau_if.sv =====
// item channel interfaces of the modular arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
interface mau_in_if;
    logic                               valid;
    logic                               ready;
    mau_pkg::t_op                       operation;
    mau_pkg::t_residue                  value_a;
    mau_pkg::t_residue                  value_b;
    logic signed [mau_pkg::EXP_W-1:0]   signed_value;
    mau_pkg::t_exp                      exponent_or_count;

    modport source (output valid, operation, value_a, value_b, signed_value,
                    exponent_or_count, input ready);
    modport sink (input valid, operation, value_a, value_b, signed_value,
                  exponent_or_count, output ready);
endinterface

interface mau_out_if;
    logic              valid;
    logic              ready;
    mau_pkg::t_residue result;
    logic              operands_equal;
    logic              a_below_b;
    logic              count_too_large;

    modport source (output valid, result, operands_equal, a_below_b, count_too_large,
                    input ready);
    modport sink (input valid, result, operands_equal, a_below_b, count_too_large,
                  output ready);
endinterface
`default_nettype wire

// ===== design/mau_mulmod.sv =====
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
`timescale 1ns / 1ps
`default_nettype none
module mau_mulmod (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire mau_pkg::t_residue i_mcand,
    input  wire mau_pkg::t_residue i_mplier,
    input  wire mau_pkg::t_residue i_modulus,
    output mau_pkg::t_ser_stat     o_stat,
    output mau_pkg::t_residue      o_prod
);
    mau_pkg::t_residue               r_acc;
    mau_pkg::t_residue               r_mcand;
    mau_pkg::t_residue               r_mplier;
    logic [mau_pkg::MUL_CNT_W-1:0]   r_cnt;
    logic                            r_busy;
    logic                            r_done;

    mau_pkg::t_residue_x dbl;
    mau_pkg::t_residue_x dbl_red;
    mau_pkg::t_residue_x sum;
    mau_pkg::t_residue_x sum_red;
    mau_pkg::t_residue_x m_x;

    // acc = 2*acc + bit*a, each kept below the modulus
    always_comb begin
        m_x     = {1'b0, i_modulus};
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= m_x) ? dbl - m_x : dbl;
        sum     = dbl_red + {1'b0, r_mcand};
        if (!r_mplier[mau_pkg::RESIDUE_WIDTH-1]) begin
            sum_red = dbl_red;
        end else if (sum >= m_x) begin
            sum_red = sum - m_x;
        end else begin
            sum_red = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= mau_pkg::MUL_CNT_W'(mau_pkg::RESIDUE_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - mau_pkg::MUL_CNT_W'(1);
                if (r_cnt == mau_pkg::MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            r_acc    <= sum_red[mau_pkg::RESIDUE_WIDTH-1:0];
            r_mplier <= {r_mplier[mau_pkg::RESIDUE_WIDTH-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_acc;
endmodule
`default_nettype wire

// ===== design/mau_redmod.sv =====
// bit-serial reduction of a wide unsigned value, restoring remainder
`timescale 1ns / 1ps
`default_nettype none
module mau_redmod (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire mau_pkg::t_wide    i_value,
    input  wire mau_pkg::t_residue i_modulus,
    output mau_pkg::t_ser_stat     o_stat,
    output mau_pkg::t_residue      o_residue
);
    mau_pkg::t_wide                  r_shift;
    mau_pkg::t_residue               r_rem;
    logic [mau_pkg::RED_CNT_W-1:0]   r_cnt;
    logic                            r_busy;
    logic                            r_done;

    mau_pkg::t_residue_x trial;
    mau_pkg::t_residue_x trial_red;

    always_comb begin
        trial     = {r_rem, r_shift[mau_pkg::WIDE_W-1]};
        trial_red = (trial >= {1'b0, i_modulus}) ? trial - {1'b0, i_modulus} : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= mau_pkg::RED_CNT_W'(mau_pkg::WIDE_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - mau_pkg::RED_CNT_W'(1);
                if (r_cnt == mau_pkg::RED_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_shift <= i_value;
        end else if (r_busy) begin
            r_rem   <= trial_red[mau_pkg::RESIDUE_WIDTH-1:0];
            r_shift <= {r_shift[mau_pkg::WIDE_W-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_residue   = r_rem;
endmodule
`default_nettype wire

// ===== design/modular_arithmetic_unit_core.sv =====
// top level: operation sequencer of the modular arithmetic unit
// add, sub, neg, unused codes: two serial operand reductions; mul adds one serial multiply, reduce one
// more reduction; pow one squaring per exponent bit but the last, plus one multiply per set bit; inv and
// div run a power by modulus-2, div then one more multiply; binomial: two reductions and two multiplies
// per factor of k, then one inverse and one multiply; one item at a time, next accept in the cycle after
// the result register loads; sync active-low reset clears control and loads modulus 1000000007
`timescale 1ns / 1ps
`default_nettype none
module modular_arithmetic_unit_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire mau_pkg::t_residue i_cfg_data,
    mau_in_if.sink                 i_in,
    mau_out_if.source              o_out
);
    typedef enum logic [3:0] {
        S_IDLE, S_RED_A, S_RED_B, S_DISPATCH, S_RED_SV, S_BN_TERM, S_BN_MULN,
        S_BN_IDX, S_BN_MULD, S_BN_END, S_POW_BIT, S_POW_MUL, S_POW_SQ,
        S_FIN_MUL, S_DONE
    } t_state;

    t_state              r_state;
    logic                r_go;        // unit launched for the current state
    mau_pkg::t_residue   r_modulus;

    // item fields held for the whole job
    mau_pkg::t_op        r_op;
    mau_pkg::t_residue   r_ra;
    mau_pkg::t_residue   r_rb;
    mau_pkg::t_exp       r_ek;
    logic                r_eq;
    logic                r_lt;
    logic                r_big;

    // working values
    mau_pkg::t_residue   r_a;
    mau_pkg::t_residue   r_b;
    mau_pkg::t_residue   r_t;
    mau_pkg::t_residue   r_x;
    mau_pkg::t_residue   r_acc;
    mau_pkg::t_residue   r_sq;
    mau_pkg::t_residue   r_num;
    mau_pkg::t_residue   r_den;
    mau_pkg::t_residue   r_res;
    mau_pkg::t_exp       r_exp;
    mau_pkg::t_wide      r_term;      // n - i for the binomial, or the value to reduce
    mau_pkg::t_kcnt      r_kcnt;
    mau_pkg::t_kcnt      r_idx;
    logic                r_fin;       // power is followed by a final multiply

    // output register
    logic                r_out_valid;
    mau_pkg::t_residue   r_out_result;
    logic                r_out_eq;
    logic                r_out_lt;
    logic                r_out_big;

    // serial units
    logic                mul_start;
    logic                red_start;
    mau_pkg::t_residue   mul_a;
    mau_pkg::t_residue   mul_b;
    mau_pkg::t_wide      red_in;
    mau_pkg::t_ser_stat  mul_stat;
    mau_pkg::t_ser_stat  red_stat;
    mau_pkg::t_residue   mul_prod;
    mau_pkg::t_residue   red_res;

    // combinational helpers
    logic                in_acc;
    logic                out_free;
    logic                term_neg;
    mau_pkg::t_wide      term_mag;
    mau_pkg::t_residue   term_res;
    mau_pkg::t_residue   one_m;
    mau_pkg::t_residue_x add_s;
    mau_pkg::t_residue_x add_r;
    mau_pkg::t_residue_x sub_r;
    mau_pkg::t_residue   neg_r;
    logic                m_small;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // magnitude of the signed term and sign fix of its residue
    assign term_neg = r_term[mau_pkg::WIDE_W-1];
    assign term_mag = term_neg ? (~r_term) + mau_pkg::t_wide'(1) : r_term;
    assign term_res = (term_neg && (red_res != '0)) ? r_modulus - red_res : red_res;

    assign one_m   = (r_modulus == mau_pkg::t_residue'(1)) ? '0 : mau_pkg::t_residue'(1);
    assign m_small = (r_modulus < mau_pkg::t_residue'(2));

    // single-step add, subtract and negate on reduced residues
    always_comb begin
        add_s = {1'b0, r_a} + {1'b0, r_b};
        add_r = (add_s >= {1'b0, r_modulus}) ? add_s - {1'b0, r_modulus} : add_s;
        sub_r = (r_a >= r_b) ? {1'b0, r_a} - {1'b0, r_b}
                             : {1'b0, r_a} + {1'b0, r_modulus} - {1'b0, r_b};
        neg_r = (r_a != '0) ? r_modulus - r_a : '0;
    end

    // operand select for the shared units
    always_comb begin
        mul_start = 1'b0;
        red_start = 1'b0;
        mul_a     = r_acc;
        mul_b     = r_sq;
        red_in    = term_mag;
        case (r_state)
            S_RED_A: begin
                red_start = !r_go;
                red_in    = mau_pkg::t_wide'(r_ra);
            end
            S_RED_B: begin
                red_start = !r_go;
                red_in    = mau_pkg::t_wide'(r_rb);
            end
            S_RED_SV, S_BN_TERM: begin
                red_start = !r_go;
            end
            S_BN_IDX: begin
                red_start = !r_go;
                red_in    = mau_pkg::t_wide'(r_idx);
            end
            S_BN_MULN: begin
                mul_start = !r_go;
                mul_a     = r_num;
                mul_b     = r_t;
            end
            S_BN_MULD: begin
                mul_start = !r_go;
                mul_a     = r_den;
                mul_b     = r_t;
            end
            S_POW_MUL: begin
                mul_start = !r_go;
            end
            S_POW_SQ: begin
                mul_start = !r_go;
                mul_a     = r_sq;
            end
            S_FIN_MUL: begin
                mul_start = !r_go;
                mul_a     = r_x;
                mul_b     = r_acc;
            end
            default: begin
            end
        endcase
    end

    mau_mulmod u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (mul_a),
        .i_mplier  (mul_b),
        .i_modulus (r_modulus),
        .o_stat    (mul_stat),
        .o_prod    (mul_prod)
    );

    mau_redmod u_red (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (red_start),
        .i_value   (red_in),
        .i_modulus (r_modulus),
        .o_stat    (red_stat),
        .o_residue (red_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_modulus   <= mau_pkg::MOD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_modulus <= i_cfg_data;
            end
            if (mul_start || red_start) begin
                r_go <= 1'b1;
            end
            // drained result; a new one loads from the done state instead
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op  <= i_in.operation;
                        r_ra  <= i_in.value_a;
                        r_rb  <= i_in.value_b;
                        r_ek  <= i_in.exponent_or_count;
                        r_term <= {i_in.signed_value[mau_pkg::EXP_W-1], i_in.signed_value};
                        r_eq  <= (i_in.value_a == i_in.value_b);
                        r_lt  <= (i_in.value_a < i_in.value_b);
                        r_big <= (i_in.operation == mau_pkg::OP_BINOM) &&
                                 (i_in.exponent_or_count > mau_pkg::t_exp'(mau_pkg::MAX_K));
                        r_res <= '0;
                        // modulus zero: every residue field is 0
                        r_state <= (r_modulus == '0) ? S_DONE : S_RED_A;
                    end
                end
                S_RED_A: begin
                    if (red_stat.done) begin
                        r_go    <= 1'b0;
                        r_a     <= red_res;
                        r_state <= S_RED_B;
                    end
                end
                S_RED_B: begin
                    if (red_stat.done) begin
                        r_go    <= 1'b0;
                        r_b     <= red_res;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    case (r_op)
                        mau_pkg::OP_ADD: begin
                            r_res   <= add_r[mau_pkg::RESIDUE_WIDTH-1:0];
                            r_state <= S_DONE;
                        end
                        mau_pkg::OP_SUB: begin
                            r_res   <= sub_r[mau_pkg::RESIDUE_WIDTH-1:0];
                            r_state <= S_DONE;
                        end
                        mau_pkg::OP_NEG: begin
                            r_res   <= neg_r;
                            r_state <= S_DONE;
                        end
                        mau_pkg::OP_MUL: begin
                            r_x     <= r_a;
                            r_acc   <= r_b;
                            r_state <= S_FIN_MUL;
                        end
                        mau_pkg::OP_DIV: begin
                            // division by zero gives 0
                            if (r_b == '0 || m_small) begin
                                r_state <= S_DONE;
                            end else begin
                                r_sq    <= r_b;
                                r_x     <= r_a;
                                r_acc   <= one_m;
                                r_exp   <= mau_pkg::t_exp'(r_modulus - mau_pkg::t_residue'(2));
                                r_fin   <= 1'b1;
                                r_state <= S_POW_BIT;
                            end
                        end
                        mau_pkg::OP_POW: begin
                            r_sq    <= r_a;
                            r_acc   <= one_m;
                            r_exp   <= r_ek;
                            r_fin   <= 1'b0;
                            r_state <= S_POW_BIT;
                        end
                        mau_pkg::OP_INV: begin
                            if (r_a == '0 || m_small) begin
                                r_state <= S_DONE;
                            end else begin
                                r_sq    <= r_a;
                                r_acc   <= one_m;
                                r_exp   <= mau_pkg::t_exp'(r_modulus - mau_pkg::t_residue'(2));
                                r_fin   <= 1'b0;
                                r_state <= S_POW_BIT;
                            end
                        end
                        mau_pkg::OP_REDUCE: r_state <= S_RED_SV;
                        mau_pkg::OP_BINOM: begin
                            if (r_big) begin
                                r_state <= S_DONE;
                            end else begin
                                r_num   <= one_m;
                                r_den   <= one_m;
                                r_kcnt  <= r_ek[mau_pkg::KCNT_W-1:0];
                                r_idx   <= mau_pkg::t_kcnt'(1);
                                r_state <= (r_ek[mau_pkg::KCNT_W-1:0] == '0) ? S_BN_END
                                                                             : S_BN_TERM;
                            end
                        end
                        default: begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_RED_SV: begin
                    if (red_stat.done) begin
                        r_go    <= 1'b0;
                        r_res   <= term_res;
                        r_state <= S_DONE;
                    end
                end
                S_BN_TERM: begin
                    if (red_stat.done) begin
                        r_go    <= 1'b0;
                        r_t     <= term_res;
                        r_state <= S_BN_MULN;
                    end
                end
                S_BN_MULN: begin
                    if (mul_stat.done) begin
                        r_go    <= 1'b0;
                        r_num   <= mul_prod;
                        r_state <= S_BN_IDX;
                    end
                end
                S_BN_IDX: begin
                    if (red_stat.done) begin
                        r_go    <= 1'b0;
                        r_t     <= red_res;
                        r_state <= S_BN_MULD;
                    end
                end
                S_BN_MULD: begin
                    if (mul_stat.done) begin
                        r_go    <= 1'b0;
                        r_den   <= mul_prod;
                        r_term  <= r_term - mau_pkg::t_wide'(1);
                        r_idx   <= r_idx + mau_pkg::t_kcnt'(1);
                        r_kcnt  <= r_kcnt - mau_pkg::t_kcnt'(1);
                        r_state <= (r_kcnt == mau_pkg::t_kcnt'(1)) ? S_BN_END : S_BN_TERM;
                    end
                end
                S_BN_END: begin
                    // k factorial zero mod m: no inverse, result 0
                    if (r_den == '0) begin
                        r_res   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_sq    <= r_den;
                        r_x     <= r_num;
                        r_acc   <= one_m;
                        r_exp   <= mau_pkg::t_exp'(r_modulus - mau_pkg::t_residue'(2));
                        r_fin   <= 1'b1;
                        r_state <= S_POW_BIT;
                    end
                end
                S_POW_BIT: begin
                    if (r_exp == '0) begin
                        r_res   <= r_acc;
                        r_state <= r_fin ? S_FIN_MUL : S_DONE;
                    end else begin
                        r_state <= r_exp[0] ? S_POW_MUL : S_POW_SQ;
                    end
                end
                S_POW_MUL: begin
                    if (mul_stat.done) begin
                        r_go  <= 1'b0;
                        r_acc <= mul_prod;
                        // last exponent bit: skip the useless squaring
                        if (r_exp[mau_pkg::EXP_W-1:1] == '0) begin
                            r_exp   <= '0;
                            r_state <= S_POW_BIT;
                        end else begin
                            r_state <= S_POW_SQ;
                        end
                    end
                end
                S_POW_SQ: begin
                    if (mul_stat.done) begin
                        r_go    <= 1'b0;
                        r_sq    <= mul_prod;
                        r_exp   <= r_exp >> 1;
                        r_state <= S_POW_BIT;
                    end
                end
                S_FIN_MUL: begin
                    if (mul_stat.done) begin
                        r_go    <= 1'b0;
                        r_res   <= mul_prod;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_result <= r_res;
                        r_out_eq     <= r_eq;
                        r_out_lt     <= r_lt;
                        r_out_big    <= r_big;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.result          = r_out_result;
    assign o_out.operands_equal  = r_out_eq;
    assign o_out.a_below_b       = r_out_lt;
    assign o_out.count_too_large = r_out_big;

`ifndef SYNTHESIS
    // a unit reports completion only after this sequencer launched it
    a_mul_done_launched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_stat.done |-> r_go)
        else $error("multiplier done without launch");
    a_red_done_launched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        red_stat.done |-> r_go)
        else $error("reducer done without launch");
    // both units never run at once
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_stat.busy && red_stat.busy))
        else $error("both serial units busy");
    // an oversized count always comes out as zero
    a_big_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_big) |-> (r_out_result == '0))
        else $error("count too large with nonzero result");
`endif
endmodule
`default_nettype wire

// ===== test/modular_arithmetic_unit_core_tb.sv =====
// self-checking testbench of the modular arithmetic unit core
`timescale 1ns / 1ps
module modular_arithmetic_unit_core_tb;

    localparam longint unsigned CYCLE_LIMIT  = 64'd60_000_000;
    localparam int              DRAIN_WAIT   = 300;
    localparam int              HOLD_OFF_LEN = 3000;

    typedef struct {
        mau_pkg::t_residue result;
        bit                operands_equal;
        bit                a_below_b;
        bit                count_too_large;
    } t_field_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    mau_pkg::t_residue i_cfg_data;

    mau_in_if  in_ch ();
    mau_out_if out_ch ();

    modular_arithmetic_unit_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // mirror of the modulus register
    longint unsigned field_modulus;
    t_field_result   pending_results[$];
    int              mismatch_count = 0;
    longint unsigned cycle_count = 0;
    bit              sender_idles;
    bit              receiver_idles;
    // hold-off requests from the tests, served by the receiver process
    int              hold_off_requests = 0;
    int              hold_off_served = 0;
    int              hold_off_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // prediction of one result
    // ---------------------------------------------------------------
    function automatic longint unsigned mod_mul(longint unsigned x, longint unsigned y,
                                                longint unsigned m);
        return (x * y) % m;
    endfunction

    // square and multiply over the exponent bits
    function automatic longint unsigned mod_pow(longint unsigned base, longint unsigned e,
                                                longint unsigned m);
        longint unsigned acc;
        longint unsigned sq;
        acc = 1 % m;
        sq  = base % m;
        while (e != 0) begin
            if (e[0])
                acc = mod_mul(acc, sq, m);
            sq = mod_mul(sq, sq, m);
            e  = e >> 1;
        end
        return acc;
    endfunction

    // fermat inverse, zero maps to zero
    function automatic longint unsigned mod_inv(longint unsigned x, longint unsigned m);
        if (x == 0 || m < 2)
            return 0;
        return mod_pow(x, m - 2, m);
    endfunction

    // bring a 64-bit two's complement value into 0..m-1
    function automatic longint unsigned fold_signed(logic [63:0] x, longint unsigned m);
        longint unsigned mag;
        longint unsigned r;
        mag = x[63] ? (64'd0 - x) : x;
        r   = mag % m;
        if (x[63] && r != 0)
            r = m - r;
        return r;
    endfunction

    // falling product n(n-1)..(n-k+1) over k factorial
    function automatic longint unsigned choose(logic [63:0] n, longint unsigned k,
                                               longint unsigned m);
        longint unsigned num;
        longint unsigned den;
        num = 1 % m;
        den = 1 % m;
        for (longint unsigned i = 0; i < k; i++) begin
            num = mod_mul(num, fold_signed(n - i, m), m);
            den = mod_mul(den, (i + 1) % m, m);
        end
        return mod_mul(num, mod_inv(den, m), m);
    endfunction

    function automatic t_field_result compute_residue_result(mau_pkg::t_op op,
                                                             mau_pkg::t_residue raw_a,
                                                             mau_pkg::t_residue raw_b,
                                                             logic [62:0] sval,
                                                             mau_pkg::t_exp ek);
        t_field_result   r;
        longint unsigned m;
        longint unsigned a;
        longint unsigned b;
        longint unsigned res;
        logic [63:0]     sx;
        m  = field_modulus;
        sx = {sval[62], sval};
        r.operands_equal  = (raw_a == raw_b);
        r.a_below_b       = (raw_a < raw_b);
        r.count_too_large = (op == mau_pkg::OP_BINOM) && (ek > mau_pkg::MAX_K);
        res = 0;
        if (m != 0) begin
            a = raw_a % m;
            b = raw_b % m;
            case (op)
                mau_pkg::OP_ADD:    res = (a + b) % m;
                mau_pkg::OP_SUB:    res = (a + m - b) % m;
                mau_pkg::OP_MUL:    res = mod_mul(a, b, m);
                mau_pkg::OP_DIV:    res = mod_mul(a, mod_inv(b, m), m);
                mau_pkg::OP_NEG:    res = (a != 0) ? (m - a) : 0;
                mau_pkg::OP_POW:    res = mod_pow(a, ek, m);
                mau_pkg::OP_INV:    res = mod_inv(a, m);
                mau_pkg::OP_REDUCE: res = fold_signed(sx, m);
                mau_pkg::OP_BINOM:  res = r.count_too_large ? 0 : choose(sx, ek, m);
                default:            res = 0;
            endcase
        end
        r.result = mau_pkg::t_residue'(res);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------
    // one item onto the input channel; expectation queued at acceptance
    task automatic send_item(mau_pkg::t_op op, mau_pkg::t_residue a, mau_pkg::t_residue b,
                             logic [62:0] sval, mau_pkg::t_exp ek);
        while (sender_idles && $urandom_range(99) < 10) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.operation         <= op;
        in_ch.value_a           <= a;
        in_ch.value_b           <= b;
        in_ch.signed_value      <= sval;
        in_ch.exponent_or_count <= ek;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        pending_results.push_back(compute_residue_result(op, a, b, sval, ek));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // modulus write, only with the block idle
    task automatic write_modulus(mau_pkg::t_residue m);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        field_modulus = m;
    endtask

    // receiver: random stalls, plus a counted hold-off for pressure
    always @(posedge i_clk) begin
        if (hold_off_served != hold_off_requests) begin
            hold_off_served <= hold_off_requests;
            hold_off_cycles <= HOLD_OFF_LEN;
            out_ch.ready    <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            out_ch.ready    <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            out_ch.ready <= !(receiver_idles && $urandom_range(99) < 10);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_field_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result item: result=%0d", out_ch.result);
            end else begin
                exp_r = pending_results.pop_front();
                if (out_ch.result !== exp_r.result
                    || out_ch.operands_equal !== exp_r.operands_equal
                    || out_ch.a_below_b !== exp_r.a_below_b
                    || out_ch.count_too_large !== exp_r.count_too_large) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp res=%0d eq=%0b lt=%0b big=%0b,",
                                  " got res=%0d eq=%0b lt=%0b big=%0b"},
                                 exp_r.result, exp_r.operands_equal, exp_r.a_below_b,
                                 exp_r.count_too_large, out_ch.result,
                                 out_ch.operands_equal, out_ch.a_below_b,
                                 out_ch.count_too_large);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // random content helpers
    // ---------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // operand mostly below the modulus, sometimes any raw value
    function automatic mau_pkg::t_residue rand_operand();
        if ($urandom_range(9) == 0)
            return mau_pkg::t_residue'($urandom);
        return mau_pkg::t_residue'(longint'($urandom) % field_modulus);
    endfunction

    // exponent of random bit length, mostly short to keep runs brief
    function automatic mau_pkg::t_exp rand_exponent();
        int bits;
        bits = ($urandom_range(9) == 0) ? $urandom_range(63, 1) : $urandom_range(20, 0);
        return mau_pkg::t_exp'(rand64() >> (64 - bits));
    endfunction

    function automatic mau_pkg::t_exp rand_count();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            return mau_pkg::t_exp'($urandom_range(12));
        if (pick < 93)
            return mau_pkg::t_exp'($urandom_range(mau_pkg::MAX_K, 13));
        if (pick < 97)
            return mau_pkg::t_exp'(mau_pkg::MAX_K + 1 + $urandom_range(40));
        return mau_pkg::t_exp'(rand64());
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        mau_pkg::t_residue top;
        top = mau_pkg::t_residue'(field_modulus - 1);
        send_item(mau_pkg::OP_ADD, top, top, 63'd0, 63'd0);
        send_item(mau_pkg::OP_SUB, 31'd0, top, 63'd0, 63'd0);
        send_item(mau_pkg::OP_MUL, top, mau_pkg::t_residue'(top - 1), 63'd0, 63'd0);
        send_item(mau_pkg::OP_DIV, 31'd12345, 31'd0, 63'd0, 63'd0);     // division by zero
        send_item(mau_pkg::OP_DIV, 31'd1, 31'd7, 63'd0, 63'd0);
        send_item(mau_pkg::OP_NEG, 31'd0, 31'd0, 63'd0, 63'd0);         // equal operands
        send_item(mau_pkg::OP_NEG, 31'd5, 31'd9, 63'd0, 63'd0);
        send_item(mau_pkg::OP_POW, 31'd0, 31'd1, 63'd0, 63'd0);         // zero to the zero
        send_item(mau_pkg::OP_POW, top, 31'd0, 63'd0, {63{1'b1}});      // full exponent
        send_item(mau_pkg::OP_INV, 31'd0, 31'd0, 63'd0, 63'd0);
        send_item(mau_pkg::OP_INV, 31'd1, 31'd2, 63'd0, 63'd0);
        send_item(mau_pkg::OP_INV, top, 31'd0, 63'd0, 63'd0);
        send_item(mau_pkg::OP_REDUCE, 31'd0, 31'd0, {1'b1, 62'd0}, 63'd0);      // most negative
        send_item(mau_pkg::OP_REDUCE, 31'd0, 31'd0, {1'b0, {62{1'b1}}}, 63'd0); // most positive
        send_item(mau_pkg::OP_REDUCE, 31'd0, 31'd0, {63{1'b1}}, 63'd0);         // minus one
        send_item(mau_pkg::OP_BINOM, 31'd0, 31'd0, 63'd10, 63'd0);      // k zero
        send_item(mau_pkg::OP_BINOM, 31'd0, 31'd0, 63'd100, mau_pkg::t_exp'(mau_pkg::MAX_K));
        send_item(mau_pkg::OP_BINOM, 31'd0, 31'd0, 63'd100,
                  mau_pkg::t_exp'(mau_pkg::MAX_K + 1));                 // count too large
        send_item(mau_pkg::OP_BINOM, 31'd0, 31'd0, 63'd5, {63{1'b1}});
        send_item(mau_pkg::OP_BINOM, 31'd0, 31'd0, -63'sd7, 63'd3);     // negative n
        send_item(mau_pkg::OP_BINOM, 31'd0, 31'd0, 63'd3, 63'd5);       // k above n
        send_item(mau_pkg::OP_ADD, {31{1'b1}}, 31'd3, 63'd0, 63'd0);    // operand at or above modulus
        send_item(mau_pkg::t_op'(9), 31'd4, 31'd4, 63'd0, 63'd0);       // unused codes
        send_item(mau_pkg::t_op'(15), 31'd4, 31'd8, 63'd0, 63'd0);
    endtask

    task automatic test_random(int count);
        mau_pkg::t_op      op;
        mau_pkg::t_residue a;
        mau_pkg::t_residue b;
        logic [62:0]       sval;
        mau_pkg::t_exp     ek;
        for (int i = 0; i < count; i++) begin
            op   = ($urandom_range(19) == 0) ? mau_pkg::t_op'($urandom_range(15, 9))
                                             : mau_pkg::t_op'($urandom_range(8));
            a    = rand_operand();
            b    = ($urandom_range(7) == 0) ? a : rand_operand();
            sval = 63'(rand64() >> $urandom_range(63, 1));
            if ($urandom_range(1))
                sval = -sval;
            ek   = (op == mau_pkg::OP_BINOM) ? rand_count() : rand_exponent();
            if (op == mau_pkg::OP_BINOM && $urandom_range(3) == 0)
                sval = 63'($urandom_range(80));                         // small n hits zeros
            send_item(op, a, b, sval, ek);
        end
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        hold_off_requests = hold_off_requests + 1;
        for (int i = 0; i < 20; i++)
            send_item(mau_pkg::t_op'($urandom_range(4)), rand_operand(), rand_operand(),
                      63'd0, 63'd0);
    endtask

    initial begin
        mau_pkg::t_residue moduli[8];
        moduli = '{mau_pkg::t_residue'(2147483647), mau_pkg::t_residue'(2),
                   mau_pkg::t_residue'(3), mau_pkg::t_residue'(65537),
                   mau_pkg::t_residue'(998244353), mau_pkg::t_residue'(1000000),
                   mau_pkg::t_residue'(97), mau_pkg::t_residue'(1000000007)};
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_data      <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= '0;
        in_ch.value_a   <= '0;
        in_ch.value_b   <= '0;
        in_ch.signed_value      <= '0;
        in_ch.exponent_or_count <= '0;
        field_modulus   = mau_pkg::MOD_RESET;
        sender_idles    = 1'b1;
        receiver_idles  = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset modulus first, then extremes
        test_directed();
        write_modulus(mau_pkg::t_residue'(2147483647));
        test_directed();
        write_modulus(mau_pkg::t_residue'(2));
        test_directed();

        foreach (moduli[i]) begin
            write_modulus(moduli[i]);
            // one chunk runs without any idling
            sender_idles   = (i != 3);
            receiver_idles = (i != 3);
            test_random(180);
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        test_backpressure();

        wait_drained();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/mau_pkg.sv
design/mau_if.sv
design/mau_mulmod.sv
design/mau_redmod.sv
design/modular_arithmetic_unit_core.sv
test/modular_arithmetic_unit_core_tb.sv
